/* src/pfs_pkg.sv */
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants for the PPM frame sequencer: item and result
// transaction layouts, configuration register indexes, reset values and the
// stage record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package pfs_pkg;

  // Default number of output channels in a frame.
  localparam int CHANNELS_DEFAULT = 8;

  // Field widths.
  localparam int FRAME_W = 15;
  localparam int MID_W   = 12;
  localparam int RANGE_W = 10;
  localparam int CHAN_W  = 4;
  localparam int VALUE_W = 16;
  localparam int TOP_W   = 16;
  localparam int ADDR_W  = CHAN_W + 1;
  localparam int QUOT_W  = 14;

  // Reset values.
  localparam logic [FRAME_W-1:0] FRAME_RESET = 15'd22000;
  localparam logic [MID_W-1:0]   MID_RESET   = 12'd1500;
  localparam logic [RANGE_W-1:0] RANGE_RESET = 10'd600;

  // Reciprocal of five, scaled by 2^18; exact for dividends below 2^17.
  localparam logic [15:0] DIV5_MULT  = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  // Operation codes.
  typedef enum logic {
    OP_SET_CHANNEL = 1'b0,
    OP_SEGMENT_END = 1'b1
  } pfs_op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FRAME_US = 2'd0,
    CFG_MID_US   = 2'd1,
    CFG_RANGE_US = 2'd2
  } pfs_cfg_e;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = FRAME_W;

  typedef struct packed {
    logic                      operation;
    logic [CHAN_W-1:0]         channel;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [TOP_W-1:0]   segment_top;
    logic               frame_start;
    logic               accepting;
    logic [15:0]        overrun_count;
    logic [FRAME_W-1:0] max_frame_us;
  } result_t;

  // Work handed from the accept stage to the timing/write stage.
  typedef struct packed {
    logic              is_seg;
    logic              frame_end;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              neg;
    logic [QUOT_W-1:0] quot;
    logic              accepting;
    logic [15:0]       overruns;
  } pfs_stage_t;

endpackage

/* src/pfs_bank_mem.sv */
// ----------------------------------------------------------------------------
// pfs_bank_mem
// Two channel banks of sixteen 12-bit entries in one synchronous memory.
// Registered read; an entry never written since reset reads as the mid reset time.
// ----------------------------------------------------------------------------
module pfs_bank_mem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [pfs_pkg::ADDR_W-1:0] wr_addr,
  input  logic [pfs_pkg::MID_W-1:0]  wr_data,
  input  logic                       rd_en,
  input  logic [pfs_pkg::ADDR_W-1:0] rd_addr,
  output logic [pfs_pkg::MID_W-1:0]  rd_data
);
  import pfs_pkg::*;

  localparam int Depth = 2 ** ADDR_W;

  logic [MID_W-1:0] mem [Depth];
  logic [Depth-1:0] written;
  logic [MID_W-1:0] rd_raw;
  logic             rd_ok;

  // Storage array and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // Per-entry written flags, cleared at reset, sampled with the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_raw : MID_RESET;

endmodule

/* src/pfs_front.sv */
// ----------------------------------------------------------------------------
// pfs_front
// Accept stage: takes item transactions, keeps bank selection, set status,
// channel pointer and overrun count, issues the bank read and scales the
// channel value by two fifths.
// ----------------------------------------------------------------------------
module pfs_front #(
  parameter int CHANNELS = pfs_pkg::CHANNELS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pfs_pkg::item_t             item,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic                       advance,
  output logic                       st_valid,
  output pfs_pkg::pfs_stage_t        st,
  output logic                       rd_en,
  output logic [pfs_pkg::ADDR_W-1:0] rd_addr
);
  import pfs_pkg::*;

  localparam logic [CHAN_W:0] ChanLimit = (CHAN_W + 1)'(CHANNELS);
  localparam logic [CHAN_W:0] LastChan  = (CHAN_W + 1)'(CHANNELS - 1);

  logic              active_bank;
  logic              active_bank_next;
  logic              set_done;
  logic              set_done_next;
  logic [CHAN_W-1:0] next_channel;
  logic [CHAN_W-1:0] next_channel_next;
  logic [15:0]       overruns;
  logic [15:0]       overruns_next;
  logic              accept;
  logic              in_range;
  logic              frame_end;
  logic [15:0]       magnitude;
  logic [16:0]       dividend;
  logic [32:0]       product;
  pfs_stage_t        st_next;

  assign item_stall = st_valid && !advance;
  assign accept     = item_valid && !item_stall;
  assign rd_en      = accept;
  assign rd_addr    = {active_bank, next_channel};

  // Magnitude of twice the value divided by five via the scaled reciprocal.
  assign magnitude = item.value[VALUE_W-1] ? 16'(-item.value) : 16'(item.value);
  assign dividend  = {magnitude, 1'b0};
  assign product   = 33'(dividend) * 33'(DIV5_MULT);

  // Control state update and stage record for the accepted item.
  always_comb begin
    in_range          = {1'b0, item.channel} < ChanLimit;
    frame_end         = {1'b0, next_channel} >= ChanLimit;
    active_bank_next  = active_bank;
    set_done_next     = set_done;
    next_channel_next = next_channel;
    overruns_next     = overruns;
    if (item.operation == OP_SET_CHANNEL) begin
      if (in_range && ({1'b0, item.channel} == LastChan)) begin
        set_done_next = 1'b1;
      end
    end else begin
      if (frame_end) begin
        if (set_done) begin
          set_done_next    = 1'b0;
          active_bank_next = !active_bank;
        end else begin
          overruns_next = overruns + 16'd1;
        end
        next_channel_next = '0;
      end else begin
        next_channel_next = next_channel + CHAN_W'(1);
      end
    end
    st_next.is_seg    = item.operation == OP_SEGMENT_END;
    st_next.frame_end = frame_end;
    st_next.wr_en     = (item.operation == OP_SET_CHANNEL) && in_range;
    st_next.wr_addr   = {!active_bank, item.channel};
    st_next.neg       = item.value[VALUE_W-1];
    st_next.quot      = product[DIV5_SHIFT +: QUOT_W];
    st_next.accepting = !set_done_next;
    st_next.overruns  = overruns_next;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_bank  <= 1'b0;
      set_done     <= 1'b1;
      next_channel <= '0;
      overruns     <= '0;
      st_valid     <= 1'b0;
    end else begin
      if (accept) begin
        active_bank  <= active_bank_next;
        set_done     <= set_done_next;
        next_channel <= next_channel_next;
        overruns     <= overruns_next;
        st_valid     <= 1'b1;
      end else if (advance) begin
        st_valid <= 1'b0;
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      st <= st_next;
    end
  end

endmodule

/* src/pfs_back.sv */
// ----------------------------------------------------------------------------
// pfs_back
// Timing stage: clips and writes channel times into the inactive bank,
// turns bank reads into segment tops, tracks elapsed and maximum frame time
// and holds the result transaction register.
// ----------------------------------------------------------------------------
module pfs_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        st_valid,
  input  pfs_pkg::pfs_stage_t         st,
  output logic                        advance,
  input  logic [pfs_pkg::MID_W-1:0]   rd_data,
  input  logic [pfs_pkg::FRAME_W-1:0] frame_us,
  input  logic [pfs_pkg::MID_W-1:0]   mid_us,
  input  logic [pfs_pkg::RANGE_W-1:0] range_us,
  output logic                        wr_en,
  output logic [pfs_pkg::ADDR_W-1:0]  wr_addr,
  output logic [pfs_pkg::MID_W-1:0]   wr_data,
  output pfs_pkg::result_t            result,
  output logic                        result_valid,
  input  logic                        result_stall
);
  import pfs_pkg::*;

  logic [TOP_W-1:0]   elapsed;
  logic [TOP_W-1:0]   elapsed_next;
  logic [TOP_W-1:0]   max_frame;
  logic [TOP_W-1:0]   max_frame_next;
  logic [TOP_W-1:0]   frame_half;
  logic [TOP_W-1:0]   chan_half;
  logic [TOP_W-1:0]   top_m1;
  logic signed [16:0] mid_s;
  logic signed [16:0] delta;
  logic signed [16:0] t_raw;
  logic signed [16:0] lo;
  logic signed [16:0] hi;
  logic signed [16:0] t_clip;
  logic               fire;
  result_t            result_next;

  assign advance = !result_valid || !result_stall;
  assign fire    = st_valid && advance;

  // Channel time: mid plus scaled value, clipped to the window and 12 bits.
  always_comb begin
    mid_s = $signed({5'b0, mid_us});
    delta = st.neg ? -$signed({3'b0, st.quot}) : $signed({3'b0, st.quot});
    t_raw = mid_s + delta;
    lo    = mid_s - $signed({7'b0, range_us});
    hi    = mid_s + $signed({7'b0, range_us});
    t_clip = t_raw;
    if (t_clip < lo) begin
      t_clip = lo;
    end
    if (t_clip > hi) begin
      t_clip = hi;
    end
    if (t_clip < 17'sd0) begin
      t_clip = 17'sd0;
    end
    if (t_clip > 17'sd4095) begin
      t_clip = 17'sd4095;
    end
  end

  assign wr_en   = fire && st.wr_en;
  assign wr_addr = st.wr_addr;
  assign wr_data = t_clip[MID_W-1:0];

  // Segment top, elapsed time and maximum frame for a segment end.
  always_comb begin
    frame_half     = {frame_us, 1'b0};
    chan_half      = {3'b0, rd_data, 1'b0};
    elapsed_next   = elapsed;
    max_frame_next = max_frame;
    top_m1         = '0;
    if (st.is_seg) begin
      if (st.frame_end) begin
        // The gap fills the frame, so elapsed plus gap is the frame length.
        top_m1       = frame_half + ~elapsed;
        elapsed_next = '0;
        if (frame_half > max_frame) begin
          max_frame_next = frame_half;
        end
      end else begin
        top_m1       = chan_half - TOP_W'(1);
        elapsed_next = elapsed + chan_half;
      end
    end
    result_next.segment_top   = top_m1;
    result_next.frame_start   = st.is_seg && st.frame_end;
    result_next.accepting     = st.accepting;
    result_next.overrun_count = st.overruns;
    result_next.max_frame_us  = max_frame_next[TOP_W-1:1];
  end

  // Timing state and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed      <= '0;
      max_frame    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (fire) begin
        elapsed      <= elapsed_next;
        max_frame    <= max_frame_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

endmodule

/* src/ppm_frame_sequencer_top.sv */
// ----------------------------------------------------------------------------
// ppm_frame_sequencer_top
// PPM frame sequencer with double-buffered channel banks and a config port.
// Result path: an accepted item is held in the stage register, then its
// result in the result register; a result stall holds it in the stage.
// Throughput: one item per cycle unless the result stalls; the bank read at
// accept and the write as the stage moves on keep to one access each per cycle.
// Reset: synchronous; banks read as the mid reset time until written,
// with per-entry flags cleared at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module ppm_frame_sequencer_top #(
  parameter int CHANNELS = pfs_pkg::CHANNELS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pfs_pkg::item_t                item,
  input  logic                          item_valid,
  output logic                          item_stall,
  output pfs_pkg::result_t              result,
  output logic                          result_valid,
  input  logic                          result_stall,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pfs_pkg::*;

  logic [FRAME_W-1:0] frame_us;
  logic [MID_W-1:0]   mid_us;
  logic [RANGE_W-1:0] range_us;
  logic               advance;
  logic               st_valid;
  pfs_stage_t         st;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [MID_W-1:0]   rd_data;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [MID_W-1:0]   wr_data;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_us <= FRAME_RESET;
      mid_us   <= MID_RESET;
      range_us <= RANGE_RESET;
    end else if (cfg_valid) begin
      case (pfs_cfg_e'(cfg_index))
        CFG_FRAME_US: frame_us <= cfg_data[FRAME_W-1:0];
        CFG_MID_US:   mid_us   <= cfg_data[MID_W-1:0];
        CFG_RANGE_US: range_us <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  pfs_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .advance    (advance),
    .st_valid   (st_valid),
    .st         (st),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  pfs_bank_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pfs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .st_valid     (st_valid),
    .st           (st),
    .advance      (advance),
    .rd_data      (rd_data),
    .frame_us     (frame_us),
    .mid_us       (mid_us),
    .range_us     (range_us),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule
